[design/greedy_graph_coloring_defines.svh]
// Assertion macros used by the checker of the graph coloring block.
`ifndef GREEDY_GRAPH_COLORING_DEFINES_SVH
`define GREEDY_GRAPH_COLORING_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/ggc_pkg.sv]
// Shared constants, types and helpers of the graph coloring block.
package ggc_pkg;

  localparam int NUM_V      = 64;
  localparam int VIDX_W     = $clog2(NUM_V);
  localparam int CNT_W      = VIDX_W + 1;
  localparam int NUM_COLORS = 10;
  localparam int COLOR_W    = 4;
  localparam int ACTION_W   = 2;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EDGE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd2;

  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(NUM_V);

  // Write request into the adjacency RAM, with a per-bit write enable.
  typedef struct packed {
    logic              we;
    logic [VIDX_W-1:0] addr;
    logic [NUM_V-1:0]  data;
    logic [NUM_V-1:0]  mask;
  } adj_wr_t;

  // Control from the sequencer to the color picker.
  typedef struct packed {
    logic              clear;
    logic              commit;
    logic [VIDX_W-1:0] vertex;
    logic [CNT_W-1:0]  count;
  } color_ctl_t;

  function automatic logic [NUM_V-1:0] vbit(input logic [VIDX_W-1:0] idx);
    return NUM_V'(1) << idx;
  endfunction

endpackage

[design/ggc_adj_ram.sv]
// Adjacency matrix RAM: one row per vertex, bit-enable write, registered read.
module ggc_adj_ram (
  input  logic                        clk,
  input  ggc_pkg::adj_wr_t            wr,
  input  logic                        ren,
  input  logic [ggc_pkg::VIDX_W-1:0]  raddr,
  output logic [ggc_pkg::NUM_V-1:0]   rdata
);
  import ggc_pkg::*;

  logic [NUM_V-1:0] mem [NUM_V];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      for (int i = 0; i < NUM_V; i++) begin
        if (wr.mask[i]) begin
          mem[wr.addr][i] <= wr.data[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ggc_color_pick.sv]
// Per-color vertex sets and the first-fit color choice for one adjacency row.
module ggc_color_pick (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ggc_pkg::color_ctl_t         ctl,
  input  logic [ggc_pkg::NUM_V-1:0]   row,
  output logic [ggc_pkg::COLOR_W-1:0] color
);
  import ggc_pkg::*;

  // Entry c holds one bit per vertex that currently has color c+1.
  logic [NUM_V-1:0]      cset_r [NUM_COLORS];
  logic [NUM_V-1:0]      cnt_mask;
  logic [NUM_V-1:0]      nbr;
  logic [NUM_COLORS-1:0] used;

  always_comb begin
    for (int j = 0; j < NUM_V; j++) begin
      cnt_mask[j] = CNT_W'(j) < ctl.count;
    end
    // A vertex never blocks itself.
    nbr = row & cnt_mask & ~vbit(ctl.vertex);
    for (int c = 0; c < NUM_COLORS; c++) begin
      used[c] = |(nbr & cset_r[c]);
    end
    color = '0;
    for (int c = NUM_COLORS - 1; c >= 0; c--) begin
      if (!used[c]) begin
        color = COLOR_W'(c + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int c = 0; c < NUM_COLORS; c++) begin
        cset_r[c] <= '0;
      end
    end else if (ctl.commit) begin
      for (int c = 0; c < NUM_COLORS; c++) begin
        cset_r[c][ctl.vertex] <= (color == COLOR_W'(c + 1));
      end
    end
  end

endmodule

[design/greedy_graph_coloring.sv]
// Top level of the greedy first-fit graph coloring block.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+---------------------------------
//   in_     | in        | in_valid/in_ready | action, vertex_a, vertex_b
//   out_    | out       | out_valid/ready   | vertex_index, color, last
//   cfg_    | in (APB)  | psel/penable      | vertex_count at byte address 0
//
// Clear drops row valid bits and color sets at once.
// Add edge writes row a, then row b (only one row for a self-loop), through the
// single write port of the adjacency RAM.
// A run reads one RAM row per cycle while out_ready does not stall it; each
// row goes through the registered RAM read, then through the output register.
// A stalled out_ready holds the row read and the whole run; the next item is
// taken while the final result still waits in the output register.
// Reset runs no clearing pass: rows without a valid bit read as zero.
module greedy_graph_coloring (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ggc_pkg::ACTION_W-1:0]  in_action,
  input  logic [ggc_pkg::VIDX_W-1:0]    in_vertex_a,
  input  logic [ggc_pkg::VIDX_W-1:0]    in_vertex_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ggc_pkg::VIDX_W-1:0]    out_vertex_index,
  output logic [ggc_pkg::COLOR_W-1:0]   out_color,
  output logic                          out_last,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ggc_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [ggc_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [ggc_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import ggc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EDGE_B, S_RUN} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  vcount_r;
  logic [NUM_V-1:0]  row_vld_r;

  // Second endpoint write of an edge.
  logic [VIDX_W-1:0] edge_a_r;
  logic [VIDX_W-1:0] edge_b_r;

  // Run sequencing: read issue counter and the stage holding a read row.
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  iss_r;
  logic              rv_r;
  logic [VIDX_W-1:0] rv_vtx_r;
  logic              rv_last_r;
  logic              rv_rowv_r;

  logic              out_valid_r;
  logic [VIDX_W-1:0] out_vtx_r;
  logic [COLOR_W-1:0] out_color_r;
  logic              out_last_r;

  logic              accept;
  logic              cfg_wr;
  logic              commit;
  logic              ren;
  logic [VIDX_W-1:0] raddr;
  logic [CNT_W-1:0]  n_sat;
  logic [VIDX_W-1:0] wbit;
  logic [NUM_V-1:0]  rdata;
  logic [NUM_V-1:0]  row;
  logic [COLOR_W-1:0] pick;
  adj_wr_t           wr;
  color_ctl_t        cctl;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2:2] == REG_VERTEX_COUNT) ?
                      DATA_W'(vcount_r) : '0;

  // Saturate the vertex count to the matrix size.
  assign n_sat = (vcount_r > CNT_W'(NUM_V)) ? CNT_W'(NUM_V) : vcount_r;

  // Write one row per cycle; a row without its valid bit is written whole.
  always_comb begin
    wr.we   = (accept && in_action == ACT_EDGE) || (state_r == S_EDGE_B);
    wr.addr = (state_r == S_EDGE_B) ? edge_b_r : in_vertex_a;
    wbit    = (state_r == S_EDGE_B) ? edge_a_r : in_vertex_b;
    wr.data = vbit(wbit);
    wr.mask = row_vld_r[wr.addr] ? vbit(wbit) : '1;
  end

  // Advance the run when the row stage is empty or hands its vertex on.
  assign commit = rv_r && (!out_valid_r || out_ready);
  assign ren    = (state_r == S_RUN) && (iss_r < n_r) && (!rv_r || commit);
  assign raddr  = iss_r[VIDX_W-1:0];
  assign row    = rv_rowv_r ? rdata : '0;

  always_comb begin
    cctl.clear  = accept && (in_action == ACT_CLEAR);
    cctl.commit = commit;
    cctl.vertex = rv_vtx_r;
    cctl.count  = n_r;
  end

  ggc_adj_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .ren   (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  ggc_color_pick u_pick (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .row   (row),
    .color (pick)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= VCOUNT_RESET;
      row_vld_r   <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      n_r         <= '0;
    end else begin
      if (cfg_wr && cfg_paddr[2:2] == REG_VERTEX_COUNT) begin
        vcount_r <= cfg_pwdata[CNT_W-1:0];
      end

      // Drop every row on clear; mark each written row.
      if (cctl.clear) begin
        row_vld_r <= '0;
      end else if (wr.we) begin
        row_vld_r[wr.addr] <= 1'b1;
      end

      case (state_r)
        S_IDLE: begin
          if (accept && in_action == ACT_EDGE && in_vertex_a != in_vertex_b) begin
            edge_a_r <= in_vertex_a;
            edge_b_r <= in_vertex_b;
            state_r  <= S_EDGE_B;
          end else if (accept && in_action == ACT_RUN && n_sat != '0) begin
            n_r     <= n_sat;
            iss_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_EDGE_B: begin
          state_r <= S_IDLE;
        end
        S_RUN: begin
          if (commit && rv_last_r) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (ren) begin
        iss_r     <= iss_r + CNT_W'(1);
        rv_r      <= 1'b1;
        rv_vtx_r  <= raddr;
        rv_last_r <= (iss_r + CNT_W'(1)) == n_r;
        rv_rowv_r <= row_vld_r[raddr];
      end else if (commit) begin
        rv_r <= 1'b0;
      end

      // Load the output register on commit; hold it while stalled.
      if (commit) begin
        out_valid_r <= 1'b1;
        out_vtx_r   <= rv_vtx_r;
        out_color_r <= pick;
        out_last_r  <= rv_last_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_vtx_r;
  assign out_color        = out_color_r;
  assign out_last         = out_last_r;

endmodule

[design/ggc_checker.sv]
// Port-level checker for the graph coloring block, bound to the top level.
`include "greedy_graph_coloring_defines.svh"

module ggc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [ggc_pkg::ACTION_W-1:0]  in_action,
  input logic [ggc_pkg::VIDX_W-1:0]    in_vertex_a,
  input logic [ggc_pkg::VIDX_W-1:0]    in_vertex_b,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ggc_pkg::VIDX_W-1:0]    out_vertex_index,
  input logic [ggc_pkg::COLOR_W-1:0]   out_color,
  input logic                          out_last
);
  import ggc_pkg::*;

  `GGC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_vertex_index) && $stable(out_color) && $stable(out_last), "result changed while stalled")

  `GGC_ASSERT_IMP(a_color_range, out_valid, out_color <= COLOR_W'(NUM_COLORS), "color out of range")

  `GGC_ASSERT_NXT(a_edge_busy, in_valid && in_ready && in_action == ACT_EDGE && in_vertex_a != in_vertex_b, !in_ready, "edge item did not take its second row write")

  `GGC_ASSERT_IMP(a_run_busy, out_valid && !out_last, !in_ready, "item taken before a run finished")

endmodule

bind greedy_graph_coloring ggc_checker u_ggc_checker (.*);
